@@ hw/rtl/otsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared types, widths and sequencer states for the Otsu threshold block.
// Wide products are formed limb by limb on one narrow multiplier.
// ----------------------------------------------------------------------------
package otsu_pkg;

	// Image and histogram geometry
	localparam int LEVELS     = 256;
	localparam int LVL_W      = 8;
	localparam int MAX_PIXELS = 1048576;

	// Running totals: N (pixel count) and S (level sum)
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = $clog2(longint'(LEVELS - 1) * longint'(MAX_PIXELS) + 64'd1);

	// Score terms: |S*W - U*N|, its square, W*(N-W), cross products
	localparam int MAG_W = SUM_W + CNT_W;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int DEN_W = 2 * CNT_W;
	localparam int CMP_W = SQ_W + DEN_W;

	// Limb arithmetic on a LIMB_W x LIMB_W multiplier
	localparam int LIMB_W = 25;
	localparam int CNT_L  = (CNT_W + LIMB_W - 1) / LIMB_W;
	localparam int SUM_L  = (SUM_W + LIMB_W - 1) / LIMB_W;
	localparam int MAG_L  = (MAG_W + LIMB_W - 1) / LIMB_W;
	localparam int SQ_L   = (SQ_W + LIMB_W - 1) / LIMB_W;
	localparam int DEN_L  = (DEN_W + LIMB_W - 1) / LIMB_W;

	// Square is the widest A operand; magnitude the widest B operand (S >= N)
	localparam int A_L  = SQ_L;
	localparam int B_L  = MAG_L;
	localparam int A_W  = A_L * LIMB_W;
	localparam int B_W  = B_L * LIMB_W;
	localparam int P_L  = A_L + B_L;
	localparam int P_W  = P_L * LIMB_W;
	localparam int IA_W = (A_L > 1) ? $clog2(A_L) : 1;
	localparam int IB_W = (B_L > 1) ? $clog2(B_L) : 1;
	localparam int K_W  = $clog2(P_L);

	// Index of the top limb of each operand kind
	localparam logic [IA_W-1:0] LVL_LAST   = '0;
	localparam logic [IA_W-1:0] SUM_LAST   = IA_W'(SUM_L - 1);
	localparam logic [IA_W-1:0] CNT_LAST_A = IA_W'(CNT_L - 1);
	localparam logic [IA_W-1:0] MAG_LAST_A = IA_W'(MAG_L - 1);
	localparam logic [IA_W-1:0] SQ_LAST    = IA_W'(SQ_L - 1);
	localparam logic [IB_W-1:0] CNT_LAST_B = IB_W'(CNT_L - 1);
	localparam logic [IB_W-1:0] MAG_LAST_B = IB_W'(MAG_L - 1);
	localparam logic [IB_W-1:0] DEN_LAST_B = IB_W'(DEN_L - 1);

	// Channel payloads
	typedef struct packed {
		logic [LVL_W-1:0] pixel;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic [LVL_W-1:0] threshold;
		logic             no_split;
		logic             overflow;
	} res_t;

	// Multiplier request and response
	typedef struct packed {
		logic            start;
		logic [A_W-1:0]  a;
		logic [B_W-1:0]  b;
		logic [IA_W-1:0] a_last;
		logic [IB_W-1:0] b_last;
	} mul_req_t;

	typedef struct packed {
		logic           done;
		logic [P_W-1:0] prod;
	} mul_rsp_t;

	// Sweep sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_READ,
		ST_RDATA,
		ST_MUL_U,
		ST_CHECK,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_SQ,
		ST_MUL_DEN,
		ST_MUL_L,
		ST_MUL_R,
		ST_NEXT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/otsu_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_mul
// Multi-limb unsigned multiplier: one LIMB_W x LIMB_W product per cycle,
// registered, then shifted into a wide accumulator.
// ----------------------------------------------------------------------------
module otsu_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  otsu_pkg::mul_req_t req,
	output otsu_pkg::mul_rsp_t rsp
);
	import otsu_pkg::*;

	logic [A_L-1:0][LIMB_W-1:0] a_q;
	logic [B_L-1:0][LIMB_W-1:0] b_q;
	logic [IA_W-1:0]            a_last_q;
	logic [IB_W-1:0]            b_last_q;
	logic [IA_W-1:0]            i_q;
	logic [IB_W-1:0]            j_q;
	logic                       issue_q;
	logic                       last_pair;
	logic                       v_s1;
	logic                       last_s1;
	logic [2*LIMB_W-1:0]        p_s1;
	logic [K_W-1:0]             k_s1;
	logic [P_W-1:0]             acc_q;
	logic                       done_q;

	assign last_pair = (i_q == a_last_q) && (j_q == b_last_q);

	// Limb-pair sequencing: j inner, i outer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (req.start) begin
				issue_q <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
			end else if (issue_q) begin
				if (last_pair) begin
					issue_q <= 1'b0;
				end
				if (j_q == b_last_q) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			v_s1    <= issue_q;
			last_s1 <= issue_q && last_pair;
			done_q  <= v_s1 && last_s1;
		end
	end

	// Operands, partial product, accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q      <= req.a;
			b_q      <= req.b;
			a_last_q <= req.a_last;
			b_last_q <= req.b_last;
		end
		p_s1 <= a_q[i_q] * b_q[j_q];
		k_s1 <= K_W'(i_q) + K_W'(j_q);
		if (req.start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= acc_q + (P_W'(p_s1) << (LIMB_W * k_s1));
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule
`default_nettype wire

@@ hw/rtl/otsu_threshold_from_histogram.sv @@
// Pixels: one transfer per cycle while pix_ready is high; no result until the last pixel.
// Last pixel: pix_ready drops for the 256-level sweep, whose products run on the limb
// multiplier (one 25x25 partial product per cycle); pix_ready returns with the result.
// A result waiting in the output register does not block the next image's pixels, but
// that image's sweep holds in ST_OUT until the waiting result is taken.
// Reset clears control, totals and the per-bin valid bits at once; no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_threshold_from_histogram
// Streams 8-bit pixels into a 256-bin histogram, then sweeps the levels and
// picks Otsu's threshold by exact integer cross-multiplied score compares.
// ----------------------------------------------------------------------------
module otsu_threshold_from_histogram (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_ready,
	input  otsu_pkg::pix_t pix,
	output logic           res_valid,
	input  logic           res_ready,
	output otsu_pkg::res_t res
);
	import otsu_pkg::*;

	state_t state_q, state_d;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// Histogram memory and per-bin valid bits
	logic [CNT_W-1:0]  bin_mem [LEVELS];
	logic [LEVELS-1:0] bin_valid_q;
	logic [LVL_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  rd_data_q;
	logic              rd_valid_q;
	logic [CNT_W-1:0]  rd_count;

	// Read-modify-write pipeline
	logic              hist_v_s1, hist_v_s2;
	logic [LVL_W-1:0]  hist_addr_s1, hist_addr_s2;
	logic [CNT_W-1:0]  hist_cnt_s2;
	logic [CNT_W-1:0]  hist_new;

	// Image totals
	logic [CNT_W-1:0]  n_q;
	logic [SUM_W-1:0]  s_q;
	logic              ovf_q;

	// Sweep datapath
	logic [LVL_W-1:0]  level_q;
	logic [CNT_W-1:0]  w_q;
	logic [SUM_W-1:0]  u_q;
	logic [MAG_W-1:0]  sw_q;
	logic [MAG_W-1:0]  un;
	logic [MAG_W-1:0]  mag;
	logic [SQ_W-1:0]   sq_q, best_sq_q;
	logic [DEN_W-1:0]  den_q, best_den_q;
	logic [CMP_W-1:0]  lhs_q;
	logic [LVL_W-1:0]  best_level_q;
	logic              found_q;
	logic              skip_level;
	logic              better;

	// Output register
	logic              res_valid_q;
	res_t              res_q;

	logic              pix_take;
	logic              room;
	logic              res_load;

	assign pix_ready = (state_q == ST_IDLE);
	assign pix_take  = pix_valid && pix_ready;
	assign room      = (n_q < CNT_W'(MAX_PIXELS));
	assign res_load  = (state_q == ST_OUT) && (!res_valid_q || res_ready);

	// ---------------- histogram ----------------

	assign rd_addr  = (state_q == ST_IDLE) ? pix.pixel : level_q;
	assign rd_count = rd_valid_q ? rd_data_q : '0;

	// Forward the previous write when it hits the same bin
	assign hist_new = ((hist_v_s2 && (hist_addr_s2 == hist_addr_s1)) ? hist_cnt_s2 : rd_count)
		+ 1'b1;

	always_ff @(posedge clk) begin
		rd_data_q <= bin_mem[rd_addr];
		if (hist_v_s1) begin
			bin_mem[hist_addr_s1] <= hist_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			hist_v_s1   <= 1'b0;
			hist_v_s2   <= 1'b0;
		end else begin
			if (res_load) begin
				bin_valid_q <= '0;
			end else if (hist_v_s1) begin
				bin_valid_q[hist_addr_s1] <= 1'b1;
			end
			rd_valid_q <= bin_valid_q[rd_addr];
			hist_v_s1  <= pix_take && room;
			hist_v_s2  <= hist_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		hist_addr_s1 <= pix.pixel;
		hist_addr_s2 <= hist_addr_s1;
		hist_cnt_s2  <= hist_new;
	end

	// Pixel count, level sum, capacity flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			s_q   <= '0;
			ovf_q <= 1'b0;
		end else if (res_load) begin
			n_q   <= '0;
			s_q   <= '0;
			ovf_q <= 1'b0;
		end else if (pix_take) begin
			if (room) begin
				n_q <= n_q + 1'b1;
				s_q <= s_q + SUM_W'(pix.pixel);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// ---------------- sweep ----------------

	assign un         = mrsp.prod[MAG_W-1:0];
	assign mag        = (sw_q >= un) ? (sw_q - un) : (un - sw_q);
	assign skip_level = (w_q == '0) || (w_q == n_q);
	assign better     = lhs_q > mrsp.prod[CMP_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_take && pix.last_pixel) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_READ;
			ST_READ:   state_d = ST_RDATA;
			ST_RDATA:  state_d = ST_MUL_U;
			ST_MUL_U: begin
				if (mrsp.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = skip_level ? ST_NEXT : ST_MUL_A;
			ST_MUL_A: begin
				if (mrsp.done) begin
					state_d = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				if (mrsp.done) begin
					state_d = (mag == '0) ? ST_NEXT : ST_MUL_SQ;
				end
			end
			ST_MUL_SQ: begin
				if (mrsp.done) begin
					state_d = ST_MUL_DEN;
				end
			end
			ST_MUL_DEN: begin
				if (mrsp.done) begin
					state_d = found_q ? ST_MUL_L : ST_NEXT;
				end
			end
			ST_MUL_L: begin
				if (mrsp.done) begin
					state_d = ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				if (mrsp.done) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT:   state_d = (level_q == LVL_W'(LEVELS - 1)) ? ST_OUT : ST_READ;
			ST_OUT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Multiplier requests
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_RDATA: begin
				// level * count
				mreq.start  = 1'b1;
				mreq.a      = A_W'(level_q);
				mreq.a_last = LVL_LAST;
				mreq.b      = B_W'(rd_count);
				mreq.b_last = CNT_LAST_B;
			end
			ST_CHECK: begin
				// S * W
				mreq.start  = !skip_level;
				mreq.a      = A_W'(s_q);
				mreq.a_last = SUM_LAST;
				mreq.b      = B_W'(w_q);
				mreq.b_last = CNT_LAST_B;
			end
			ST_MUL_A: begin
				// U * N
				mreq.start  = mrsp.done;
				mreq.a      = A_W'(u_q);
				mreq.a_last = SUM_LAST;
				mreq.b      = B_W'(n_q);
				mreq.b_last = CNT_LAST_B;
			end
			ST_MUL_B: begin
				// magnitude squared
				mreq.start  = mrsp.done && (mag != '0);
				mreq.a      = A_W'(mag);
				mreq.a_last = MAG_LAST_A;
				mreq.b      = B_W'(mag);
				mreq.b_last = MAG_LAST_B;
			end
			ST_MUL_SQ: begin
				// W * (N - W)
				mreq.start  = mrsp.done;
				mreq.a      = A_W'(w_q);
				mreq.a_last = CNT_LAST_A;
				mreq.b      = B_W'(n_q - w_q);
				mreq.b_last = CNT_LAST_B;
			end
			ST_MUL_DEN: begin
				// new square * best denominator
				mreq.start  = mrsp.done && found_q;
				mreq.a      = A_W'(sq_q);
				mreq.a_last = SQ_LAST;
				mreq.b      = B_W'(best_den_q);
				mreq.b_last = DEN_LAST_B;
			end
			ST_MUL_L: begin
				// best square * new denominator
				mreq.start  = mrsp.done;
				mreq.a      = A_W'(best_sq_q);
				mreq.a_last = SQ_LAST;
				mreq.b      = B_W'(den_q);
				mreq.b_last = DEN_LAST_B;
			end
			ST_IDLE, ST_DRAIN, ST_READ, ST_MUL_U, ST_MUL_R, ST_NEXT, ST_OUT: begin
				mreq = '0;
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN) begin
				level_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == ST_NEXT) begin
				level_q <= level_q + 1'b1;
			end else if ((state_q == ST_MUL_DEN) && mrsp.done) begin
				found_q <= 1'b1;
			end
		end
	end

	// Sweep accumulators and best candidate
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DRAIN: begin
				w_q          <= '0;
				u_q          <= '0;
				best_level_q <= '0;
			end
			ST_RDATA: begin
				w_q <= w_q + rd_count;
			end
			ST_MUL_U: begin
				if (mrsp.done) begin
					u_q <= u_q + mrsp.prod[SUM_W-1:0];
				end
			end
			ST_MUL_A: begin
				if (mrsp.done) begin
					sw_q <= mrsp.prod[MAG_W-1:0];
				end
			end
			ST_MUL_SQ: begin
				if (mrsp.done) begin
					sq_q <= mrsp.prod[SQ_W-1:0];
				end
			end
			ST_MUL_DEN: begin
				if (mrsp.done) begin
					den_q <= mrsp.prod[DEN_W-1:0];
					// first positive score is taken as is
					if (!found_q) begin
						best_sq_q    <= sq_q;
						best_den_q   <= mrsp.prod[DEN_W-1:0];
						best_level_q <= level_q;
					end
				end
			end
			ST_MUL_L: begin
				if (mrsp.done) begin
					lhs_q <= mrsp.prod[CMP_W-1:0];
				end
			end
			ST_MUL_R: begin
				// strictly greater, so ties keep the lower level
				if (mrsp.done && better) begin
					best_sq_q    <= sq_q;
					best_den_q   <= den_q;
					best_level_q <= level_q;
				end
			end
			ST_IDLE, ST_READ, ST_CHECK, ST_MUL_B, ST_NEXT, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// ---------------- result ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.threshold <= found_q ? best_level_q : '0;
			res_q.no_split  <= !found_q;
			res_q.overflow  <= ovf_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	otsu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

endmodule
`default_nettype wire

@@ hw/rtl/otsu_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_checker
// Port-level checks for the Otsu threshold block, bound to the top level.
// ----------------------------------------------------------------------------
module otsu_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_valid,
	input logic           pix_ready,
	input otsu_pkg::pix_t pix,
	input logic           res_valid,
	input logic           res_ready,
	input otsu_pkg::res_t res
);
	import otsu_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Last pixel transfer starts the sweep, input closes
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.last_pixel |=> !pix_ready)
		else $error("input still open after last pixel");

	// Sweep end loads the result and reopens input together
	a_res_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $rose(pix_ready))
		else $error("result appeared outside sweep end");

	// No split means a zero threshold
	a_no_split_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.no_split |-> res.threshold == '0)
		else $error("no_split with nonzero threshold");

endmodule

bind otsu_threshold_from_histogram otsu_checker u_otsu_checker (.*);
`default_nettype wire

@@ dv/otsu_threshold_from_histogram_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otsu_threshold_from_histogram_tb
// Streams gray images into the Otsu block and checks every threshold against
// a local histogram sweep that scores levels with exact wide-integer compares.
// Covers the range ends, ties, flat images and random images.
// ----------------------------------------------------------------------------
module otsu_threshold_from_histogram_tb;
	import otsu_pkg::*;

	localparam int STALL_LIMIT = 60000;
	localparam int SETTLE_CYCLES = 12000;

	// Pending pixel plus pacing hints for the driver
	typedef struct packed {
		pix_t px;
		logic no_gap;
		logic drain_first;
	} pixel_slot_t;

	typedef enum int {
		IMG_FLAT,
		IMG_NOISE,
		IMG_TWO_PEAK,
		IMG_SPARSE
	} img_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	pixel_slot_t pixels_pending[$];
	res_t thresholds_due[$];
	logic steady = 1'b0;
	int errors = 0;
	int idle_cycles = 0;

	// Local histogram state
	longint unsigned hist_bins[LEVELS];
	longint unsigned hist_total = 0;
	longint unsigned hist_sum = 0;
	logic hist_dropped = 1'b0;

	otsu_threshold_from_histogram i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sweep all levels; keep the first strictly best between-class score
	function automatic res_t otsu_pick();
		longint unsigned w, u, a, b;
		logic [159:0] mag, sq, den, best_sq, best_den, lhs, rhs;
		logic found;
		res_t r;
		w = 0;
		u = 0;
		found = 1'b0;
		best_sq = '0;
		best_den = '0;
		r = '0;
		for (int i = 0; i < LEVELS; i++) begin
			w += hist_bins[i];
			u += hist_bins[i] * i;
			if (w == 0 || w == hist_total)
				continue;
			a = hist_sum * w;
			b = u * hist_total;
			mag = (a >= b) ? a - b : b - a;
			if (mag == 0)
				continue;
			sq = mag * mag;
			den = w;
			den = den * (hist_total - w);
			// score_i > score_best  <=>  sq_i * den_best > sq_best * den_i
			if (found) begin
				lhs = sq * best_den;
				rhs = best_sq * den;
				if (!(lhs > rhs))
					continue;
			end
			found = 1'b1;
			best_sq = sq;
			best_den = den;
			r.threshold = LVL_W'(i);
		end
		r.no_split = !found;
		r.overflow = hist_dropped;
		return r;
	endfunction

	// Count one accepted pixel; on the last one queue the expected threshold
	task automatic count_pixel(input pix_t p);
		if (hist_total < MAX_PIXELS) begin
			hist_bins[p.pixel]++;
			hist_total++;
			hist_sum += p.pixel;
		end else begin
			hist_dropped = 1'b1;
		end
		if (p.last_pixel) begin
			thresholds_due = {thresholds_due, otsu_pick()};
			foreach (hist_bins[i])
				hist_bins[i] = 0;
			hist_total = 0;
			hist_sum = 0;
			hist_dropped = 1'b0;
		end
	endtask

	task automatic queue_pixel(input logic [LVL_W-1:0] lvl, input logic last,
			input logic no_gap, input logic drain_first);
		pixel_slot_t s;
		s.px.pixel = lvl;
		s.px.last_pixel = last;
		s.no_gap = no_gap;
		s.drain_first = drain_first;
		pixels_pending = {pixels_pending, s};
	endtask

	// One image of len pixels with the chosen gray-level profile
	task automatic queue_image(input int len, input img_kind_t kind,
			input logic no_gap, input logic drain_first);
		int lo_c, hi_c, spread, lvl;
		int picks[3];
		lo_c = $urandom_range(0, 127);
		hi_c = $urandom_range(128, 255);
		spread = $urandom_range(0, 40);
		foreach (picks[k])
			picks[k] = $urandom_range(0, 255);
		for (int j = 0; j < len; j++) begin
			case (kind)
				IMG_FLAT: begin
					lvl = lo_c;
				end
				IMG_NOISE: begin
					lvl = $urandom_range(0, 255);
				end
				IMG_TWO_PEAK: begin
					lvl = ($urandom_range(0, 1) ? hi_c : lo_c)
						+ int'($urandom_range(0, 2 * spread)) - spread;
					lvl = (lvl < 0) ? 0 : (lvl > 255) ? 255 : lvl;
				end
				default: begin
					lvl = picks[$urandom_range(0, 2)];
				end
			endcase
			queue_pixel(LVL_W'(lvl), j == len - 1, no_gap, drain_first && j == 0);
		end
	endtask

	// Pixel driver: hold valid and payload until the transfer completes
	always @(posedge clk) begin : drive_pixels
		logic go;
		pixel_slot_t nxt;
		if (arst_n) begin
			if (pix_valid && pix_ready)
				count_pixel(pix);
			if (!pix_valid || pix_ready) begin
				go = 1'b0;
				nxt = '0;
				if (pixels_pending.size() != 0) begin
					nxt = pixels_pending[0];
					if (nxt.drain_first && thresholds_due.size() != 0)
						go = 1'b0;
					else if (!nxt.no_gap && $urandom_range(0, 99) < 38)
						go = 1'b0;
					else
						go = 1'b1;
				end
				if (go) begin
					void'(pixels_pending.pop_front());
					pix <= nxt.px;
					steady <= nxt.no_gap;
				end
				pix_valid <= go;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expected threshold
	always @(posedge clk) begin : watch_results
		res_t due;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (thresholds_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got thr=%0d ns=%0b ov=%0b",
						$time, res.threshold, res.no_split, res.overflow);
				end else begin
					due = thresholds_due.pop_front();
					if (res.threshold !== due.threshold) begin
						errors++;
						$display("%0t: threshold mismatch, expected %0d, got %0d",
							$time, due.threshold, res.threshold);
					end
					if (res.no_split !== due.no_split) begin
						errors++;
						$display("%0t: no_split mismatch, expected %0b, got %0b",
							$time, due.no_split, res.no_split);
					end
					if (res.overflow !== due.overflow) begin
						errors++;
						$display("%0t: overflow mismatch, expected %0b, got %0b",
							$time, due.overflow, res.overflow);
					end
				end
			end
			res_ready <= steady || ($urandom_range(0, 99) >= 38);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [LVL_W-1:0] patterns[8];
		int n_items, n_imgs, len;
		img_kind_t kind;
		patterns = '{8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h01, 8'hFE};
		foreach (hist_bins[i])
			hist_bins[i] = 0;

		// Single pixel at each end of the range: no split
		queue_pixel(8'h00, 1'b1, 1'b0, 1'b0);
		queue_pixel(8'hFF, 1'b1, 1'b0, 1'b0);
		// Extremes only: every level scores the same, lowest wins
		queue_pixel(8'h00, 1'b0, 1'b0, 1'b0);
		queue_pixel(8'hFF, 1'b1, 1'b0, 1'b0);
		// Flat image
		repeat (3)
			queue_pixel(8'd128, 1'b0, 1'b0, 1'b0);
		queue_pixel(8'd128, 1'b1, 1'b0, 1'b0);
		// Tie across levels 10..19
		queue_pixel(8'd10, 1'b0, 1'b0, 1'b0);
		queue_pixel(8'd20, 1'b0, 1'b0, 1'b0);
		queue_pixel(8'd20, 1'b0, 1'b0, 1'b0);
		queue_pixel(8'd10, 1'b1, 1'b0, 1'b0);
		// Alternating bit patterns
		foreach (patterns[k])
			queue_pixel(patterns[k], k == 7, 1'b0, 1'b0);

		// Random images, mostly small; a run of them without back-pressure,
		// and some that wait until every threshold has come back
		n_items = 0;
		n_imgs = 0;
		while (n_items < 1250 || n_imgs < 40) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 60);
			case ($urandom_range(0, 9))
				0: kind = IMG_FLAT;
				1, 2, 3: kind = IMG_NOISE;
				4, 5: kind = IMG_SPARSE;
				default: kind = IMG_TWO_PEAK;
			endcase
			queue_image(len, kind, n_imgs >= 12 && n_imgs < 20,
				n_imgs == 24 || $urandom_range(0, 9) == 0);
			n_items += len;
			n_imgs++;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pixels_pending.size() != 0 || pix_valid || thresholds_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
